FILE: sv/urp_pkg.sv
package urp_pkg;

    // Item kinds
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;
    localparam logic [1:0] REQ_RX    = 2'd3;

    // Register offsets from the base address
    localparam logic [15:0] OFS_DATA   = 16'd0;
    localparam logic [15:0] OFS_CTRL   = 16'd1;
    localparam logic [15:0] OFS_STATUS = 16'd2;
    localparam logic [15:0] OFS_BAUD   = 16'd3;

    // Status bit positions
    localparam int ST_TXRDY = 0;
    localparam int ST_RXDA  = 1;
    localparam int ST_FE    = 2;
    localparam int ST_OE    = 3;

    // Control bit positions
    localparam int CT_TXEN = 0;
    localparam int CT_TXIE = 1;
    localparam int CT_RXIE = 2;

    localparam logic [15:0] UNMAPPED_READ = 16'hFFFF;
    localparam logic [3:0]  DATA_BITS     = 4'd8;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] bus_address;
        logic [15:0] write_data;
        logic [7:0]  rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        tx_done;
        logic [7:0]  tx_byte;
        logic        irq;
    } out_item_t;

    typedef struct packed {
        logic        we;
        logic [15:0] wdata;
    } cfg_t;

endpackage

FILE: sv/urp_core.sv
module urp_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  urp_pkg::cfg_t       cfg,
    input  logic                en,
    input  urp_pkg::in_item_t   item,
    output urp_pkg::out_item_t  result
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_START = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;
    localparam logic [1:0] PH_STOP  = 2'd3;

    logic [15:0] base_reg;
    logic [15:0] control_reg,  control_next;
    logic [3:0]  flags_reg,    flags_next;
    logic [15:0] baud_reg,     baud_next;
    logic [1:0]  phase_reg,    phase_next;
    logic [7:0]  shift_reg,    shift_next;
    logic [3:0]  bits_reg,     bits_next;
    logic [15:0] count_reg,    count_next;
    logic [7:0]  rx_reg,       rx_next;
    logic        irq_reg,      irq_next;

    logic [15:0] offset;
    logic [16:0] count_inc;
    logic        period_over;
    logic [3:0]  bits_inc;

    assign offset      = item.bus_address - base_reg;
    assign count_inc   = {1'b0, count_reg} + 17'd1;
    assign period_over = count_inc >= {1'b0, baud_reg};
    assign bits_inc    = bits_reg + 4'd1;

    always_comb begin
        control_next = control_reg;
        flags_next   = flags_reg;
        baud_next    = baud_reg;
        phase_next   = phase_reg;
        shift_next   = shift_reg;
        bits_next    = bits_reg;
        count_next   = count_reg;
        rx_next      = rx_reg;
        irq_next     = irq_reg;
        result       = '0;

        case (item.req_type)
            urp_pkg::REQ_TICK: begin
                if (phase_reg != PH_IDLE) begin
                    count_next = period_over ? 16'd0 : count_inc[15:0];
                end
                case (phase_reg)
                    PH_START: begin
                        if (period_over) begin
                            phase_next = PH_DATA;
                            bits_next  = 4'd0;
                        end
                    end
                    PH_DATA: begin
                        if (period_over) begin
                            bits_next = bits_inc;
                            if (bits_inc >= urp_pkg::DATA_BITS) phase_next = PH_STOP;
                        end
                    end
                    PH_STOP: begin
                        if (period_over) begin
                            phase_next                    = PH_IDLE;
                            flags_next[urp_pkg::ST_TXRDY] = 1'b1;
                            result.tx_done                = 1'b1;
                            result.tx_byte                = shift_reg;
                        end
                    end
                    default: ;
                endcase
                irq_next = (flags_next[urp_pkg::ST_TXRDY] && control_reg[urp_pkg::CT_TXIE]) ||
                           (flags_next[urp_pkg::ST_RXDA]  && control_reg[urp_pkg::CT_RXIE]);
            end
            urp_pkg::REQ_READ: begin
                case (offset)
                    urp_pkg::OFS_DATA: begin
                        result.read_data             = {8'd0, rx_reg};
                        flags_next[urp_pkg::ST_RXDA] = 1'b0;
                    end
                    urp_pkg::OFS_CTRL:   result.read_data = control_reg;
                    urp_pkg::OFS_STATUS: result.read_data = {12'd0, flags_reg};
                    urp_pkg::OFS_BAUD:   result.read_data = baud_reg;
                    default:             result.read_data = urp_pkg::UNMAPPED_READ;
                endcase
            end
            urp_pkg::REQ_WRITE: begin
                case (offset)
                    urp_pkg::OFS_DATA: begin
                        if (control_reg[urp_pkg::CT_TXEN] && flags_reg[urp_pkg::ST_TXRDY]) begin
                            shift_next                    = item.write_data[7:0];
                            flags_next[urp_pkg::ST_TXRDY] = 1'b0;
                            phase_next                    = PH_START;
                            count_next                    = 16'd0;
                            bits_next                     = 4'd0;
                        end
                    end
                    urp_pkg::OFS_CTRL: control_next = item.write_data;
                    urp_pkg::OFS_STATUS: begin
                        // write one to clear, error flags only
                        if (item.write_data[urp_pkg::ST_FE]) flags_next[urp_pkg::ST_FE] = 1'b0;
                        if (item.write_data[urp_pkg::ST_OE]) flags_next[urp_pkg::ST_OE] = 1'b0;
                    end
                    urp_pkg::OFS_BAUD: baud_next = item.write_data;
                    default: ;
                endcase
            end
            default: begin
                if (flags_reg[urp_pkg::ST_RXDA]) flags_next[urp_pkg::ST_OE] = 1'b1;
                rx_next                      = item.rx_byte;
                flags_next[urp_pkg::ST_RXDA] = 1'b1;
            end
        endcase

        result.irq = irq_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg    <= '0;
            control_reg <= '0;
            flags_reg   <= 4'(1 << urp_pkg::ST_TXRDY);
            baud_reg    <= '0;
            phase_reg   <= PH_IDLE;
            shift_reg   <= '0;
            bits_reg    <= '0;
            count_reg   <= '0;
            rx_reg      <= '0;
            irq_reg     <= 1'b0;
        end else begin
            if (cfg.we) base_reg <= cfg.wdata;
            if (en) begin
                control_reg <= control_next;
                flags_reg   <= flags_next;
                baud_reg    <= baud_next;
                phase_reg   <= phase_next;
                shift_reg   <= shift_next;
                bits_reg    <= bits_next;
                count_reg   <= count_next;
                rx_reg      <= rx_next;
                irq_reg     <= irq_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_idle_iff_txrdy: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) == flags_reg[urp_pkg::ST_TXRDY])
        else $error("transmitter phase and TXRDY disagree");

    a_bits_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        bits_reg <= urp_pkg::DATA_BITS)
        else $error("bit count beyond data bits");

    a_fe_never_set: assert property (@(posedge aclk) disable iff (!aresetn)
        !flags_reg[urp_pkg::ST_FE])
        else $error("framing error flag set");

    a_done_in_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        en && result.tx_done |-> phase_reg == PH_STOP)
        else $error("tx_done outside stop period");
`endif

endmodule

FILE: sv/uart_register_peripheral.sv
// Memory-mapped UART register block (8N1 timing, no line levels). Items on the s_ channel are
// clock ticks, bus reads, bus writes or injected receive bytes; each gives exactly one result
// item on the m_ channel. Registers DATA, CTRL, STATUS and BAUD sit at the base address set
// through cfg_we/cfg_wdata and the three offsets that follow. An item is held in an input
// register, processed against the register state in a single pass and lands in an output
// register, so one item is accepted every clock cycle while results are taken; m_valid rises
// once the item reaches the output register; a stalled result holds the input register, and
// s_ready drops only while both registers are full.
module uart_register_peripheral (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  urp_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output urp_pkg::out_item_t  m_item
);

    logic               in_valid_reg;
    urp_pkg::in_item_t  in_item_reg;
    logic               out_valid_reg;
    urp_pkg::out_item_t out_item_reg;
    urp_pkg::out_item_t core_result;
    urp_pkg::cfg_t      cfg;
    logic               advance;

    // Advance the held item once the output register is free or being emptied
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign cfg.we    = cfg_we;
    assign cfg.wdata = cfg_wdata;

    urp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .en      (advance),
        .item    (in_item_reg),
        .result  (core_result)
    );

    // Input register: take a new item while empty or whenever the held one moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) in_item_reg <= s_item;
    end

    // Output register: hold the result until the consumer takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) out_item_reg <= core_result;
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled with room to advance");

    a_accept_fills_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> in_valid_reg)
        else $error("accepted item lost from input register");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> out_valid_reg && $stable(out_item_reg))
        else $error("waiting result item dropped or changed");
`endif

endmodule

FILE: bench/uart_register_peripheral_tb.sv
`timescale 1ns / 1ps

module uart_register_peripheral_tb;

    // Phase of the transmitter, as the bench tracks it
    typedef enum logic [1:0] {
        TXP_IDLE,
        TXP_START,
        TXP_DATA,
        TXP_STOP
    } tx_phase_t;

    localparam int QUIET_LIMIT   = 1000; // cycles with no handshake before giving up
    localparam int SETTLE_CYCLES = 4;    // pipeline depth plus margin
    localparam int REPORT_LIMIT  = 10;

    // Register-level model of the peripheral plus the queue of responses still owed.
    class uart_scoreboard;
        logic [15:0] base;
        logic [15:0] ctrl;
        logic [3:0]  status;
        logic [15:0] divisor;
        tx_phase_t   phase;
        logic [7:0]  shift_byte;
        logic [3:0]  bits_sent;
        logic [15:0] tick_count;
        logic [7:0]  rx_hold;
        logic        irq_level;

        urp_pkg::out_item_t responses_due[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned n_reads, n_writes, n_rx, n_ticks, n_sent;

        function new();
            base       = '0;
            ctrl       = '0;
            status     = '0;
            status[urp_pkg::ST_TXRDY] = 1'b1;
            divisor    = '0;
            phase      = TXP_IDLE;
            shift_byte = '0;
            bits_sent  = '0;
            tick_count = '0;
            rx_hold    = '0;
            irq_level  = 1'b0;
        endfunction

        function void set_base(logic [15:0] value);
            base = value;
        endfunction

        function int pending();
            return responses_due.size();
        endfunction

        // Count one tick of the current bit period; true when the period has run out.
        function bit period_elapsed();
            logic [16:0] next;
            next = {1'b0, tick_count} + 17'd1;
            if (next >= {1'b0, divisor}) begin
                tick_count = '0;
                return 1'b1;
            end
            tick_count = next[15:0];
            return 1'b0;
        endfunction

        function urp_pkg::out_item_t predict_response(urp_pkg::in_item_t req);
            urp_pkg::out_item_t rsp;
            logic [15:0]        ofs;
            rsp = '0;
            ofs = req.bus_address - base;
            case (req.req_type)
                urp_pkg::REQ_TICK: begin
                    n_ticks++;
                    case (phase)
                        TXP_START: if (period_elapsed()) begin
                            phase     = TXP_DATA;
                            bits_sent = '0;
                        end
                        TXP_DATA: if (period_elapsed()) begin
                            bits_sent = bits_sent + 4'd1;
                            if (bits_sent >= urp_pkg::DATA_BITS)
                                phase = TXP_STOP;
                        end
                        TXP_STOP: if (period_elapsed()) begin
                            phase                     = TXP_IDLE;
                            status[urp_pkg::ST_TXRDY] = 1'b1;
                            rsp.tx_done               = 1'b1;
                            rsp.tx_byte               = shift_byte;
                        end
                        default: ;
                    endcase
                    irq_level = (status[urp_pkg::ST_TXRDY] & ctrl[urp_pkg::CT_TXIE])
                              | (status[urp_pkg::ST_RXDA] & ctrl[urp_pkg::CT_RXIE]);
                end
                urp_pkg::REQ_READ: begin
                    n_reads++;
                    case (ofs)
                        urp_pkg::OFS_DATA: begin
                            rsp.read_data            = {8'h00, rx_hold};
                            status[urp_pkg::ST_RXDA] = 1'b0;
                        end
                        urp_pkg::OFS_CTRL:   rsp.read_data = ctrl;
                        urp_pkg::OFS_STATUS: rsp.read_data = {12'h000, status};
                        urp_pkg::OFS_BAUD:   rsp.read_data = divisor;
                        default:             rsp.read_data = urp_pkg::UNMAPPED_READ;
                    endcase
                end
                urp_pkg::REQ_WRITE: begin
                    n_writes++;
                    case (ofs)
                        urp_pkg::OFS_DATA:
                            if (ctrl[urp_pkg::CT_TXEN] && status[urp_pkg::ST_TXRDY]) begin
                                shift_byte                = req.write_data[7:0];
                                status[urp_pkg::ST_TXRDY] = 1'b0;
                                phase                     = TXP_START;
                                tick_count                = '0;
                                bits_sent                 = '0;
                            end
                        urp_pkg::OFS_CTRL: ctrl = req.write_data;
                        urp_pkg::OFS_STATUS: begin
                            if (req.write_data[urp_pkg::ST_FE]) status[urp_pkg::ST_FE] = 1'b0;
                            if (req.write_data[urp_pkg::ST_OE]) status[urp_pkg::ST_OE] = 1'b0;
                        end
                        urp_pkg::OFS_BAUD: divisor = req.write_data;
                        default: ;
                    endcase
                end
                default: begin
                    n_rx++;
                    if (status[urp_pkg::ST_RXDA])
                        status[urp_pkg::ST_OE] = 1'b1;
                    rx_hold                  = req.rx_byte;
                    status[urp_pkg::ST_RXDA] = 1'b1;
                end
            endcase
            rsp.irq = irq_level;
            return rsp;
        endfunction

        function void note_request(urp_pkg::in_item_t req);
            responses_due.push_back(predict_response(req));
        endfunction

        function void report_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] response %0d, %s: expected 0x%0h, got 0x%0h",
                             $time, checked, field, want, got);
            end
        endfunction

        function void check_response(urp_pkg::out_item_t got);
            urp_pkg::out_item_t want;
            if (responses_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] response with nothing outstanding: 0x%0h", $time, got);
                return;
            end
            want = responses_due.pop_front();
            report_field("read_data", 32'(want.read_data), 32'(got.read_data));
            report_field("tx_done", 32'(want.tx_done), 32'(got.tx_done));
            report_field("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
            report_field("irq", 32'(want.irq), 32'(got.irq));
            if (got.tx_done)
                n_sent++;
            checked++;
        endfunction
    endclass

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [15:0]        cfg_wdata = '0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    urp_pkg::in_item_t  s_item    = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    urp_pkg::out_item_t m_item;

    uart_scoreboard sb = new();

    logic [15:0] cur_base    = '0;
    bit          no_idle     = 1'b0;  // set for stretches with back-to-back traffic
    int          ready_hold  = 0;
    int          quiet_count = 0;
    int          n_bases     = 0;

    uart_register_peripheral u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Idle length: mostly none, often a short one, now and then a long pause.
    function automatic int pick_gap();
        int unsigned roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [15:0] rand16();
        return 16'($urandom);
    endfunction

    function automatic logic [7:0] rand8();
        return 8'($urandom);
    endfunction

    // Build a request against the current base; fields the kind ignores still carry noise.
    function automatic urp_pkg::in_item_t make_item(logic [1:0] kind, logic [15:0] ofs,
                                                    logic [15:0] wdata, logic [7:0] rxb);
        urp_pkg::in_item_t it;
        it.req_type    = kind;
        it.bus_address = cur_base + ofs;
        it.write_data  = wdata;
        it.rx_byte     = rxb;
        return it;
    endfunction

    // Random request, weighted so that transmissions actually run to completion:
    // plenty of ticks, control writes that mostly keep TXEN, divisors mostly tiny.
    function automatic urp_pkg::in_item_t random_request();
        urp_pkg::in_item_t it;
        int unsigned       roll;
        logic [15:0]       ofs;
        bit                wild_address;
        it.bus_address = rand16();
        it.write_data  = rand16();
        it.rx_byte     = rand8();
        wild_address   = 1'b0;
        ofs            = urp_pkg::OFS_DATA;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            it.req_type = urp_pkg::REQ_TICK;
        else if (roll < 68)
            it.req_type = urp_pkg::REQ_READ;
        else if (roll < 90)
            it.req_type = urp_pkg::REQ_WRITE;
        else
            it.req_type = urp_pkg::REQ_RX;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            ofs = urp_pkg::OFS_DATA;
        else if (roll < 60)
            ofs = urp_pkg::OFS_CTRL;
        else if (roll < 78)
            ofs = urp_pkg::OFS_STATUS;
        else if (roll < 92)
            ofs = urp_pkg::OFS_BAUD;
        else if (roll < 97)
            ofs = 16'($urandom_range(4, 16'hFFFF));
        else
            wild_address = 1'b1;
        if (!wild_address) begin
            it.bus_address = cur_base + ofs;
            if (it.req_type == urp_pkg::REQ_WRITE) begin
                if (ofs == urp_pkg::OFS_CTRL && $urandom_range(0, 99) < 85)
                    it.write_data[urp_pkg::CT_TXEN] = 1'b1;
                if (ofs == urp_pkg::OFS_BAUD && $urandom_range(0, 99) < 92)
                    it.write_data = 16'($urandom_range(0, 4));
            end
        end
        return it;
    endfunction

    // Offer one item; leave valid high after acceptance so a zero gap gives back-to-back items.
    task automatic send_item(input urp_pkg::in_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_item(make_item(urp_pkg::REQ_TICK, rand16(), rand16(), rand8()));
    endtask

    // Stop sending and hold off until every owed response has come back.
    task automatic drain_responses();
        s_valid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Only ever called with the block drained.
    task automatic write_base(input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_base = value;
        sb.set_base(value);
        n_bases++;
    endtask

    task automatic run_random_phase(input logic [15:0] base_value, input int count);
        drain_responses();
        write_base(base_value);
        repeat (count) send_item(random_request());
    endtask

    // Back-pressure on the result side: random stalls of the same shape as the sender gaps.
    always @(posedge aclk) begin
        if (ready_hold == 0)
            ready_hold = pick_gap();
        if (ready_hold != 0) begin
            m_ready <= 1'b0;
            ready_hold--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Note accepted requests before checking responses: a request is always
    // noted before its own response is checked.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_request(s_item);
        if (aresetn && m_valid && m_ready)
            sb.check_response(m_item);
    end

    // Watchdog: give up once nothing has moved on either channel for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_count = 0;
        else
            quiet_count++;
        if (quiet_count >= QUIET_LIMIT) begin
            $display("[%0t] timeout: no handshake for %0d cycles, %0d responses owed",
                     $time, QUIET_LIMIT, sb.pending());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        // Hold reset from the start, then release it once.
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_base(16'h0000);

        // Directed: reset values, unmapped decode, a full transmission at the
        // minimum bit period, overrun and write-one-to-clear status.
        send_item(make_item(urp_pkg::REQ_READ, urp_pkg::OFS_STATUS, rand16(), rand8()));
        send_item(make_item(urp_pkg::REQ_READ, urp_pkg::OFS_CTRL, rand16(), rand8()));
        send_item(make_item(urp_pkg::REQ_READ, urp_pkg::OFS_DATA, rand16(), rand8()));
        send_item(make_item(urp_pkg::REQ_READ, 16'd4, rand16(), rand8()));
        send_item(make_item(urp_pkg::REQ_READ, 16'hFFFF, rand16(), rand8()));
        // Transmitter still disabled: drop the data write.
        send_item(make_item(urp_pkg::REQ_WRITE, urp_pkg::OFS_DATA, 16'h00A5, rand8()));
        send_item(make_item(urp_pkg::REQ_TICK, rand16(), rand16(), rand8()));
        send_item(make_item(urp_pkg::REQ_WRITE, urp_pkg::OFS_CTRL, 16'hFFFF, rand8()));
        send_item(make_item(urp_pkg::REQ_WRITE, urp_pkg::OFS_BAUD, 16'h0000, rand8()));
        // Only the low byte is sent; the second write lands while busy and is dropped.
        send_item(make_item(urp_pkg::REQ_WRITE, urp_pkg::OFS_DATA, 16'hFF3C, rand8()));
        send_item(make_item(urp_pkg::REQ_WRITE, urp_pkg::OFS_DATA, 16'h0011, rand8()));
        send_ticks(10);
        // Second byte while the first is unread: overrun.
        send_item(make_item(urp_pkg::REQ_RX, rand16(), rand16(), 8'hFF));
        send_item(make_item(urp_pkg::REQ_RX, rand16(), rand16(), 8'h00));
        send_item(make_item(urp_pkg::REQ_READ, urp_pkg::OFS_STATUS, rand16(), rand8()));
        send_item(make_item(urp_pkg::REQ_WRITE, urp_pkg::OFS_STATUS, 16'hFFFF, rand8()));
        send_item(make_item(urp_pkg::REQ_READ, urp_pkg::OFS_DATA, rand16(), rand8()));
        send_item(make_item(urp_pkg::REQ_WRITE, 16'd4, 16'hFFFF, rand8()));
        send_item(make_item(urp_pkg::REQ_WRITE, urp_pkg::OFS_BAUD, 16'hFFFF, rand8()));
        send_item(make_item(urp_pkg::REQ_READ, urp_pkg::OFS_BAUD, rand16(), rand8()));
        send_item(make_item(urp_pkg::REQ_TICK, rand16(), rand16(), rand8()));

        // Random phases at several base addresses, the top of the map among them
        // so that the decode wraps; one phase runs without any idling.
        run_random_phase(rand16(), 140);
        run_random_phase(16'hFFFF, 140);
        no_idle = 1'b1;
        run_random_phase(16'hFFFE, 140);
        no_idle = 1'b0;
        run_random_phase(16'h8000, 140);
        run_random_phase(rand16(), 140);

        drain_responses();
        $display("Covered %0d ticks, %0d reads, %0d writes, %0d received bytes over %0d bases",
                 sb.n_ticks, sb.n_reads, sb.n_writes, sb.n_rx, n_bases);
        $display("Checked %0d responses, %0d transmissions completed, %0d field errors",
                 sb.checked, sb.n_sent, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
